/* sv/ydi_pkg.sv */
// Shared constants, types and small arithmetic helpers for the field deinterlacer.
// Used by yadif_deinterlace_pixel; depends on nothing else.
`default_nettype none

package ydi_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned SCORE_W      = PIX_W + 2;
  localparam int unsigned CFG_W        = 13;
  localparam int unsigned CMP_W        = CFG_W + 1;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned MAX_LINE_DEF = 4096;
  localparam int unsigned MAX_ROWS     = 4096;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned EDGE_COLS    = 3;
  localparam int unsigned WIN_DEPTH    = 2 * EDGE_COLS + 1;
  localparam int unsigned DLY_DEPTH    = EDGE_COLS + 1;
  localparam int unsigned IN_W         = 7 * PIX_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_PARITY = 2'd2;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t nb;
    pix_t na;
    pix_t pb;
    pix_t pa;
  } tpix_t;

  typedef struct packed {
    logic       emit;
    logic       last_col;
    logic       last_row;
    logic       interp;
    logic       search;
    logic [1:0] start;
  } ctrl_t;

  function automatic pix_t absd(input pix_t x, input pix_t y);
    absd = (x > y) ? (x - y) : (y - x);
  endfunction

  function automatic pix_t avg2(input pix_t x, input pix_t y);
    logic [PIX_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    avg2 = s[PIX_W:1];
  endfunction

  // Sum of three absolute differences between pixel pairs.
  function automatic logic [SCORE_W-1:0] score3(input pix_t a0, input pix_t b0,
                                                input pix_t a1, input pix_t b1,
                                                input pix_t a2, input pix_t b2);
    score3 = SCORE_W'(absd(a0, b0)) + SCORE_W'(absd(a1, b1)) + SCORE_W'(absd(a2, b2));
  endfunction

endpackage

`default_nettype wire

/* sv/yadif_deinterlace_pixel.sv */
// Pixel-stream field deinterlacer: edge-directed spatial prediction with temporal clamp.
// Depends on ydi_pkg for constants, types and the difference helpers.
`default_nettype none

// One item (a column of neighbour pixels) is taken in every clock cycle unless the output
// stalls. Each item passes a window stage, a difference stage, a prediction stage and a
// clamp stage, then an output register before its result is offered, and results lag
// the input by three columns. The last item of a line of four or more pixels releases
// four results, of a narrower line as many as the line holds; the output register sends
// them one per cycle while m_axis_tready is high, so the input pauses at the end of each
// line. tready of the input follows the output through the stage chain.
module yadif_deinterlace_pixel #(
  parameter int unsigned MAX_LINE = ydi_pkg::MAX_LINE_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Input item, tdata from bit 0 up: cur_above, cur_center, cur_below,
  // prev_above, prev_below, next_above, next_below.
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [ydi_pkg::IN_W-1:0]             s_axis_tdata,
  // Result item, tdata: out_pixel. tlast: end_of_line.
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [ydi_pkg::PIX_W-1:0]            m_axis_tdata,
  output logic                                 m_axis_tlast,
  // tuser from bit 0 up: end_of_frame, last_in_burst.
  output logic [1:0]                           m_axis_tuser,
  input  wire                                  cfg_we_i,
  input  wire  [ydi_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [ydi_pkg::CFG_W-1:0]            cfg_data_i
);

  localparam int unsigned COL_W   = $clog2(MAX_LINE);
  localparam int unsigned CMP_W   = ydi_pkg::CMP_W;
  localparam int unsigned ROW_W   = ydi_pkg::ROW_W;
  localparam int unsigned PIX_W   = ydi_pkg::PIX_W;
  localparam int unsigned SCORE_W = ydi_pkg::SCORE_W;
  localparam int unsigned WIN     = ydi_pkg::WIN_DEPTH;
  localparam int unsigned DLY     = ydi_pkg::DLY_DEPTH;
  localparam int unsigned EDGE    = ydi_pkg::EDGE_COLS;

  // ---------------------------------------------------------------- configuration
  logic [ydi_pkg::CFG_W-1:0] line_width_q, frame_height_q;
  logic                      field_parity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= ydi_pkg::LINE_WIDTH_RST;
      frame_height_q <= ydi_pkg::FRAME_HEIGHT_RST;
      field_parity_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ydi_pkg::CFG_LINE_WIDTH:   line_width_q   <= cfg_data_i;
        ydi_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        ydi_pkg::CFG_FIELD_PARITY: field_parity_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake chain
  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  logic rdy2, rdy3, rdy4, rdy_o, out_last, in_acc;
  logic [1:0] oslot_q;
  logic       olast_col_q, olast_row_q;

  assign out_last      = !olast_col_q || (oslot_q == 2'd0);
  assign rdy_o         = !ov_q || (m_axis_tready && out_last);
  assign rdy4          = !v4_q || rdy_o;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign s_axis_tready = !v1_q || rdy2;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- position control
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [CMP_W-1:0] wc, hc, col_ext, row_ext;
  ydi_pkg::ctrl_t   ctrl_in, ctrl1_q, ctrl2_q, ctrl3_q, ctrl4_q;

  always_comb begin
    // Zero counts as one; values past the maxima count as the maxima.
    if (line_width_q == '0) begin
      wc = CMP_W'(1);
    end else if (CMP_W'(line_width_q) > CMP_W'(MAX_LINE)) begin
      wc = CMP_W'(MAX_LINE);
    end else begin
      wc = CMP_W'(line_width_q);
    end
    if (frame_height_q == '0) begin
      hc = CMP_W'(1);
    end else if (CMP_W'(frame_height_q) > CMP_W'(ydi_pkg::MAX_ROWS)) begin
      hc = CMP_W'(ydi_pkg::MAX_ROWS);
    end else begin
      hc = CMP_W'(frame_height_q);
    end
    col_ext          = CMP_W'(col_q);
    row_ext          = CMP_W'(row_q);
    ctrl_in.last_col = (col_ext + CMP_W'(1)) >= wc;
    ctrl_in.last_row = (row_ext + CMP_W'(1)) >= hc;
    ctrl_in.interp   = row_q[0] ^ field_parity_q;
    ctrl_in.emit     = ctrl_in.last_col || (col_q >= COL_W'(EDGE));
    ctrl_in.start    = (col_q >= COL_W'(EDGE)) ? 2'd3 : col_q[1:0];
    // The oldest column gets the edge search only with three columns on each side.
    ctrl_in.search   = (col_q >= COL_W'(2 * EDGE)) && (col_ext < wc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (ctrl_in.last_col) begin
        col_q <= '0;
        row_q <= ctrl_in.last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: window
  ydi_pkg::pix_t  a_q [WIN];
  ydi_pkg::pix_t  b_q [WIN];
  ydi_pkg::pix_t  c_q [DLY];
  ydi_pkg::tpix_t t_q [DLY];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = WIN - 1; k > 0; k--) begin
        a_q[k] <= a_q[k-1];
        b_q[k] <= b_q[k-1];
      end
      for (int k = DLY - 1; k > 0; k--) begin
        c_q[k] <= c_q[k-1];
        t_q[k] <= t_q[k-1];
      end
      a_q[0]    <= s_axis_tdata[0*PIX_W +: PIX_W];
      c_q[0]    <= s_axis_tdata[1*PIX_W +: PIX_W];
      b_q[0]    <= s_axis_tdata[2*PIX_W +: PIX_W];
      t_q[0].pa <= s_axis_tdata[3*PIX_W +: PIX_W];
      t_q[0].pb <= s_axis_tdata[4*PIX_W +: PIX_W];
      t_q[0].na <= s_axis_tdata[5*PIX_W +: PIX_W];
      t_q[0].nb <= s_axis_tdata[6*PIX_W +: PIX_W];
      ctrl1_q   <= ctrl_in;
    end
  end

  // ---------------------------------------------------------------- stage 2: differences
  logic [PIX_W:0]      sum1_q [DLY];
  logic [PIX_W:0]      sum2_q [DLY];
  ydi_pkg::pix_t       avg_q  [DLY];
  ydi_pkg::pix_t       c2_q   [DLY];
  logic [SCORE_W-1:0]  s0_q, sm1_q, sm2_q, sp1_q, sp2_q;
  ydi_pkg::pix_t       pm1_q, pm2_q, pp1_q, pp2_q;

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      for (int k = 0; k < DLY; k++) begin
        sum1_q[k] <= {1'b0, ydi_pkg::absd(t_q[k].pa, a_q[k])}
                   + {1'b0, ydi_pkg::absd(t_q[k].pb, b_q[k])};
        sum2_q[k] <= {1'b0, ydi_pkg::absd(t_q[k].na, a_q[k])}
                   + {1'b0, ydi_pkg::absd(t_q[k].nb, b_q[k])};
        avg_q[k]  <= ydi_pkg::avg2(a_q[k], b_q[k]);
        c2_q[k]   <= c_q[k];
      end
      // Window slot 3 is the column being interpolated; lower slots lie to its right.
      s0_q  <= ydi_pkg::score3(a_q[4], b_q[4], a_q[3], b_q[3], a_q[2], b_q[2]);
      sm1_q <= ydi_pkg::score3(a_q[5], b_q[3], a_q[4], b_q[2], a_q[3], b_q[1]);
      sm2_q <= ydi_pkg::score3(a_q[6], b_q[2], a_q[5], b_q[1], a_q[4], b_q[0]);
      sp1_q <= ydi_pkg::score3(a_q[3], b_q[5], a_q[2], b_q[4], a_q[1], b_q[3]);
      sp2_q <= ydi_pkg::score3(a_q[2], b_q[6], a_q[1], b_q[5], a_q[0], b_q[4]);
      pm1_q <= ydi_pkg::avg2(a_q[4], b_q[2]);
      pm2_q <= ydi_pkg::avg2(a_q[5], b_q[1]);
      pp1_q <= ydi_pkg::avg2(a_q[2], b_q[4]);
      pp2_q <= ydi_pkg::avg2(a_q[1], b_q[5]);
      ctrl2_q <= ctrl1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3: prediction
  ydi_pkg::pix_t      diff3_q [DLY];
  ydi_pkg::pix_t      pred3_q [DLY];
  ydi_pkg::pix_t      c3_q    [DLY];
  logic               c1, c2, c3, c4;
  logic [SCORE_W-1:0] best_n;
  ydi_pkg::pix_t      pred_n, pred_s;

  always_comb begin
    // The baseline score is lowered by one, so a direction must win by at least two.
    c1     = (SCORE_W'(sm1_q) + SCORE_W'(1)) < s0_q;
    c2     = sm2_q < sm1_q;
    best_n = c2 ? sm2_q : sm1_q;
    pred_n = c1 ? (c2 ? pm2_q : pm1_q) : avg_q[EDGE];
    c3     = c1 ? (sp1_q < best_n) : ((SCORE_W'(sp1_q) + SCORE_W'(1)) < s0_q);
    c4     = sp2_q < sp1_q;
    pred_s = c3 ? (c4 ? pp2_q : pp1_q) : pred_n;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      for (int k = 0; k < DLY; k++) begin
        diff3_q[k] <= (sum1_q[k][PIX_W:1] > sum2_q[k][PIX_W:1]) ? sum1_q[k][PIX_W:1]
                                                                : sum2_q[k][PIX_W:1];
        pred3_q[k] <= ((k == EDGE) && ctrl2_q.search) ? pred_s : avg_q[k];
        c3_q[k]    <= c2_q[k];
      end
      ctrl3_q <= ctrl2_q;
    end
  end

  // ---------------------------------------------------------------- stage 4: clamp
  ydi_pkg::pix_t pix4_q [DLY];
  logic [PIX_W:0] hi  [DLY];
  ydi_pkg::pix_t  lo  [DLY];
  ydi_pkg::pix_t  res [DLY];

  always_comb begin
    for (int k = 0; k < DLY; k++) begin
      hi[k] = {1'b0, c3_q[k]} + {1'b0, diff3_q[k]};
      lo[k] = c3_q[k] - diff3_q[k];
      if ({1'b0, pred3_q[k]} > hi[k]) begin
        res[k] = hi[k][PIX_W-1:0];
      end else if ((c3_q[k] >= diff3_q[k]) && (pred3_q[k] < lo[k])) begin
        res[k] = lo[k];
      end else begin
        res[k] = pred3_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && rdy4) begin
      for (int k = 0; k < DLY; k++) begin
        pix4_q[k] <= ctrl3_q.interp ? res[k] : c3_q[k];
      end
      ctrl4_q <= ctrl3_q;
    end
  end

  // ---------------------------------------------------------------- output register
  ydi_pkg::pix_t opix_q [DLY];

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      for (int k = 0; k < DLY; k++) begin
        opix_q[k] <= pix4_q[k];
      end
      oslot_q     <= ctrl4_q.start;
      olast_col_q <= ctrl4_q.last_col;
      olast_row_q <= ctrl4_q.last_row;
    end else if (m_axis_tready) begin
      // A line end sends its remaining columns oldest first.
      oslot_q <= oslot_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (s_axis_tready) v1_q <= s_axis_tvalid;
      if (rdy2)          v2_q <= v1_q;
      if (rdy3)          v3_q <= v2_q;
      if (rdy4)          v4_q <= v3_q;
      if (rdy_o)         ov_q <= v4_q && ctrl4_q.emit;
    end
  end

  assign m_axis_tvalid   = ov_q;
  assign m_axis_tdata    = opix_q[oslot_q];
  assign m_axis_tlast    = olast_col_q && (oslot_q == 2'd0);
  assign m_axis_tuser[0] = m_axis_tlast && olast_row_q;
  assign m_axis_tuser[1] = out_last;

  // ---------------------------------------------------------------- assertions
  a_eof_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[1])
    else $error("end of frame without end of line and end of burst");

  a_single_is_slot3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !olast_col_q |-> oslot_q == 2'd3)
    else $error("mid-line result not taken from the oldest column");

  a_burst_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_last && m_axis_tready |=> ov_q && (oslot_q == $past(oslot_q) - 2'd1))
    else $error("line-end burst lost or repeated a result");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking bench for the pixel-stream field deinterlacer (yadif_deinterlace_pixel).
// Needs ydi_pkg and the block's RTL. A scoreboard class predicts every result from the
// items accepted at the input, and plain tasks drive the stream and configuration ports.
module tb_top;

  localparam int unsigned RANDOM_ITEMS = 335;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct packed {
    ydi_pkg::pix_t pixel;
    logic          eol;
    logic          eof;
    logic          burst_end;
  } out_px_t;

  typedef enum int unsigned {PAT_NOISE, PAT_FLAT, PAT_EDGE, PAT_RAIL} pattern_e;

  class deint_checker;
    logic [ydi_pkg::CFG_W-1:0] line_width;
    logic [ydi_pkg::CFG_W-1:0] frame_height;
    logic                      field_parity;
    ydi_pkg::pix_t             above_win[ydi_pkg::WIN_DEPTH];
    ydi_pkg::pix_t             below_win[ydi_pkg::WIN_DEPTH];
    ydi_pkg::pix_t             center_dly[ydi_pkg::DLY_DEPTH];
    ydi_pkg::tpix_t            temporal_dly[ydi_pkg::DLY_DEPTH];
    logic [ydi_pkg::ROW_W-1:0] column_count;
    logic [ydi_pkg::ROW_W-1:0] row_count;
    out_px_t                   expected_pixels[$];
    int unsigned               errors;
    int unsigned               results_seen;

    function new();
      line_width   = ydi_pkg::LINE_WIDTH_RST;
      frame_height = ydi_pkg::FRAME_HEIGHT_RST;
      field_parity = 1'b0;
      for (int i = 0; i < ydi_pkg::WIN_DEPTH; i++) begin
        above_win[i] = '0;
        below_win[i] = '0;
      end
      for (int i = 0; i < ydi_pkg::DLY_DEPTH; i++) begin
        center_dly[i]   = '0;
        temporal_dly[i] = '0;
      end
      column_count = '0;
      row_count    = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [ydi_pkg::CFG_IDX_W-1:0] idx,
                          logic [ydi_pkg::CFG_W-1:0] value);
      case (idx)
        ydi_pkg::CFG_LINE_WIDTH: begin
          line_width = value;
        end
        ydi_pkg::CFG_FRAME_HEIGHT: begin
          frame_height = value;
        end
        ydi_pkg::CFG_FIELD_PARITY: begin
          field_parity = value[0];
        end
        default: begin
        end
      endcase
    endfunction

    function int outstanding();
      return expected_pixels.size();
    endfunction

    function int abs_diff(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Interpolated pixel for the column held in delay slot k. Only slot 3 may run the
    // edge-directed search; window slot 3 - t holds column x + t of each line.
    function ydi_pkg::pix_t predict_interp(int unsigned k, bit search);
      int             c, d, e, td1, td2, diff, pred, best, s, j, dir, step;
      ydi_pkg::tpix_t t;
      c    = above_win[k];
      d    = center_dly[k];
      e    = below_win[k];
      t    = temporal_dly[k];
      td1  = (abs_diff(t.pa, c) + abs_diff(t.pb, e)) >> 1;
      td2  = (abs_diff(t.na, c) + abs_diff(t.nb, e)) >> 1;
      diff = (td1 > td2) ? td1 : td2;
      pred = (c + e) >> 1;
      if (search && k == 3) begin
        best = abs_diff(above_win[4], below_win[4]) + abs_diff(c, e)
             + abs_diff(above_win[2], below_win[2]) - 1;
        for (dir = -1; dir <= 1; dir += 2) begin
          for (step = 1; step <= 2; step++) begin
            j = dir * step;
            s = abs_diff(above_win[4 - j], below_win[4 + j])
              + abs_diff(above_win[3 - j], below_win[3 + j])
              + abs_diff(above_win[2 - j], below_win[2 + j]);
            if (s < best) begin
              best = s;
              pred = (int'(above_win[3 - j]) + int'(below_win[3 + j])) >> 1;
            end else begin
              break;
            end
          end
        end
      end
      if (pred > d + diff) begin
        pred = d + diff;
      end else if (pred < d - diff) begin
        pred = d - diff;
      end
      return ydi_pkg::pix_t'(pred);
    endfunction

    // Shift one accepted column into the windows and queue the pixels it releases.
    function void note_item(logic [ydi_pkg::IN_W-1:0] d);
      int unsigned w, h, col, first, x, slot;
      bit          last_col, last_row, interp, search;
      out_px_t     r;
      int          n;
      w = (line_width == 0) ? 1 : ((line_width > ydi_pkg::MAX_LINE_DEF) ?
                                   ydi_pkg::MAX_LINE_DEF : line_width);
      h = (frame_height == 0) ? 1 : ((frame_height > ydi_pkg::MAX_ROWS) ?
                                     ydi_pkg::MAX_ROWS : frame_height);
      col      = column_count;
      last_col = (col + 1 >= w);
      last_row = (row_count + 1 >= h);
      interp   = row_count[0] ^ field_parity;
      for (int i = ydi_pkg::WIN_DEPTH - 1; i > 0; i--) begin
        above_win[i] = above_win[i-1];
        below_win[i] = below_win[i-1];
      end
      for (int i = ydi_pkg::DLY_DEPTH - 1; i > 0; i--) begin
        center_dly[i]   = center_dly[i-1];
        temporal_dly[i] = temporal_dly[i-1];
      end
      above_win[0]    = d[ydi_pkg::PIX_W-1:0];
      center_dly[0]   = d[2*ydi_pkg::PIX_W-1:ydi_pkg::PIX_W];
      below_win[0]    = d[3*ydi_pkg::PIX_W-1:2*ydi_pkg::PIX_W];
      temporal_dly[0] = d[ydi_pkg::IN_W-1:3*ydi_pkg::PIX_W];
      if (col >= ydi_pkg::EDGE_COLS) begin
        first = col - ydi_pkg::EDGE_COLS;
      end else begin
        first = last_col ? 0 : col + 1;
      end
      n = 0;
      for (x = first; x <= col; x++) begin
        slot        = (col - x) & 3;
        search      = (x >= ydi_pkg::EDGE_COLS) && (x + ydi_pkg::EDGE_COLS < w);
        r.pixel     = interp ? predict_interp(slot, search) : center_dly[slot];
        r.eol       = last_col && (x == col);
        r.eof       = r.eol && last_row;
        r.burst_end = 1'b0;
        expected_pixels.push_back(r);
        n++;
        if (!last_col) break;
      end
      if (n > 0) begin
        r = expected_pixels.pop_back();
        r.burst_end = 1'b1;
        expected_pixels.push_back(r);
      end
      if (last_col) begin
        column_count = '0;
        row_count    = last_row ? '0 : ydi_pkg::ROW_W'(row_count + 1);
      end else begin
        column_count = ydi_pkg::ROW_W'(col + 1);
      end
    endfunction

    task report(string what);
      errors++;
      $display("tb_top: mismatch at %0t: %s", $time, what);
    endtask

    task check_result(ydi_pkg::pix_t pixel, logic eol, logic [1:0] flags);
      out_px_t x;
      results_seen++;
      if (expected_pixels.size() == 0) begin
        report($sformatf("pixel %0d arrived with nothing expected", pixel));
      end else begin
        x = expected_pixels.pop_front();
        if (pixel !== x.pixel)
          report($sformatf("out_pixel %0d, expected %0d", pixel, x.pixel));
        if (eol !== x.eol)
          report($sformatf("end_of_line %b, expected %b", eol, x.eol));
        if (flags[0] !== x.eof)
          report($sformatf("end_of_frame %b, expected %b", flags[0], x.eof));
        if (flags[1] !== x.burst_end)
          report($sformatf("last_in_burst %b, expected %b", flags[1], x.burst_end));
      end
    endtask
  endclass

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ydi_pkg::IN_W-1:0]      s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [ydi_pkg::PIX_W-1:0]     m_axis_tdata;
  logic                          m_axis_tlast;
  logic [1:0]                    m_axis_tuser;
  logic                          cfg_we_i      = 1'b0;
  logic [ydi_pkg::CFG_IDX_W-1:0] cfg_idx_i     = ydi_pkg::CFG_LINE_WIDTH;
  logic [ydi_pkg::CFG_W-1:0]     cfg_data_i    = '0;

  deint_checker sb = new();
  int unsigned  idle_s = 15;
  int unsigned  idle_r = 76;
  int unsigned  items_in = 0;
  int unsigned  settings = 0;
  int unsigned  quiet = 0;

  yadif_deinterlace_pixel u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= idle_r);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (rst_ni) begin
      quiet <= quiet + 1;
      if (quiet + 1 >= QUIET_LIMIT) begin
        $display("tb_top: no progress for %0d cycles", QUIET_LIMIT);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [ydi_pkg::IN_W-1:0] pack_item(
      ydi_pkg::pix_t ca, ydi_pkg::pix_t cc, ydi_pkg::pix_t cb, ydi_pkg::pix_t pa,
      ydi_pkg::pix_t pb, ydi_pkg::pix_t na, ydi_pkg::pix_t nb);
    return {nb, na, pb, pa, cb, cc, ca};
  endfunction

  function automatic ydi_pkg::pix_t near(int v, int spread);
    int t;
    t = v + int'($urandom_range(2 * spread)) - spread;
    return ydi_pkg::pix_t'((t < 0) ? 0 : ((t > 255) ? 255 : t));
  endfunction

  // Column x of a line; the edge pattern puts a step at edge_at + shift on the line above
  // and at edge_at - shift below, which is the diagonal the spatial search looks for.
  function automatic logic [ydi_pkg::IN_W-1:0] make_item(int unsigned x, pattern_e pat,
                                                         int unsigned edge_at, int shift,
                                                         ydi_pkg::pix_t lo,
                                                         ydi_pkg::pix_t hi);
    ydi_pkg::pix_t f[7];
    int            base;
    case (pat)
      PAT_FLAT: begin
        base = $urandom_range(255);
        for (int i = 0; i < 7; i++) f[i] = near(base, 6);
      end
      PAT_EDGE: begin
        f[0] = (int'(x) >= int'(edge_at) + shift) ? hi : lo;
        f[2] = (int'(x) >= int'(edge_at) - shift) ? hi : lo;
        f[1] = near((int'(f[0]) + int'(f[2])) / 2, 30);
        if ($urandom_range(1)) begin
          f[3] = near(f[0], 10);
          f[4] = near(f[2], 10);
          f[5] = near(f[0], 10);
          f[6] = near(f[2], 10);
        end else begin
          for (int i = 3; i < 7; i++) f[i] = ydi_pkg::pix_t'($urandom_range(255));
        end
      end
      PAT_RAIL: begin
        for (int i = 0; i < 7; i++) f[i] = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: begin
        for (int i = 0; i < 7; i++) f[i] = ydi_pkg::pix_t'($urandom_range(255));
      end
    endcase
    return pack_item(f[0], f[1], f[2], f[3], f[4], f[5], f[6]);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(logic [ydi_pkg::IN_W-1:0] d);
    while ($urandom_range(99) < idle_s) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(d);
    items_in++;
    @(negedge clk_i);
  endtask

  // Stop sending until every queued pixel is out, then let the pipeline run dry.
  task automatic hold_off();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_config(logic [ydi_pkg::CFG_W-1:0] w, logic [ydi_pkg::CFG_W-1:0] h,
                            logic p);
    logic [ydi_pkg::CFG_IDX_W-1:0] idx[3];
    logic [ydi_pkg::CFG_W-1:0]     val[3];
    hold_off();
    idx = '{ydi_pkg::CFG_LINE_WIDTH, ydi_pkg::CFG_FRAME_HEIGHT, ydi_pkg::CFG_FIELD_PARITY};
    val = '{w, h, ydi_pkg::CFG_W'(p)};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= val[i];
      sb.set_reg(idx[i], val[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    logic [ydi_pkg::CFG_W-1:0] w, h;
    int unsigned               weff, n, edge_at, done;
    int                        shift;
    pattern_e                  pat;
    ydi_pkg::pix_t             lo, hi;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: wide line, copy path, fields at their extremes.
    send_item(pack_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(pack_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(pack_item(8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55));
    send_item(pack_item(8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA));
    send_item(pack_item(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(pack_item(8'h00, 8'h80, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

    // Narrowing the line leaves the column count past the end: next item closes the line.
    set_config(13'd4, 13'd2, 1'b1);
    send_item(pack_item(8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70));
    for (int x = 0; x < 4; x++) send_item(make_item(x, PAT_RAIL, 0, 0, 8'h00, 8'hFF));

    // Seven-pixel lines give one column with the search, once per diagonal direction.
    set_config(13'd7, 13'd1, 1'b1);
    for (int x = 0; x < 7; x++) send_item(make_item(x, PAT_EDGE, 3, 1, 8'd20, 8'd220));
    for (int x = 0; x < 7; x++) send_item(make_item(x, PAT_EDGE, 3, -2, 8'd230, 8'd10));

    done = 0;
    while (done < RANDOM_ITEMS) begin
      case ($urandom_range(11))
        0: w = 13'd0;
        1: w = 13'd1;
        2: w = 13'd2;
        3: w = 13'h1FFF;
        4: w = 13'd4096;
        5: w = ydi_pkg::CFG_W'($urandom_range(4097, 8190));
        default: w = ydi_pkg::CFG_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(9))
        0: h = 13'd0;
        1: h = 13'h1FFF;
        2: h = 13'd4096;
        default: h = ydi_pkg::CFG_W'($urandom_range(1, 4));
      endcase
      set_config(w, h, 1'($urandom_range(1)));
      weff = (w == 0) ? 1 : ((w > ydi_pkg::MAX_LINE_DEF) ? ydi_pkg::MAX_LINE_DEF : w);
      if (weff > 16) begin
        n = $urandom_range(4, 10);
      end else begin
        n = weff * $urandom_range(1, 4);
        if ($urandom_range(1)) n += $urandom_range(weff - 1);
      end
      for (int i = 0; i < n && done < RANDOM_ITEMS; i++) begin
        if (done < RANDOM_ITEMS / 3) begin
          idle_s = 15;
          idle_r = 76;
        end else if (done < 2 * RANDOM_ITEMS / 3) begin
          idle_s = 76;
          idle_r = 15;
        end else begin
          idle_s = 0;
          idle_r = 0;
        end
        if (i == 0 || sb.column_count == 0) begin
          case ($urandom_range(19))
            0, 1:                 pat = PAT_RAIL;
            2, 3, 4, 5, 6:        pat = PAT_FLAT;
            7, 8, 9, 10, 11:      pat = PAT_NOISE;
            default:              pat = PAT_EDGE;
          endcase
          edge_at = $urandom_range((weff > 12) ? 12 : weff);
          shift   = int'($urandom_range(4)) - 2;
          lo      = ydi_pkg::pix_t'($urandom_range(255));
          hi      = ydi_pkg::pix_t'($urandom_range(255));
        end
        if ($urandom_range(39) == 0) hold_off();
        send_item(make_item(sb.column_count, pat, edge_at, shift, lo, hi));
        done++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (2 * DRAIN_CYCLES) @(negedge clk_i);

    $display("tb_top: %0d items in, %0d pixels checked, %0d register settings",
             items_in, sb.results_seen, settings);
    $display("tb_top: %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
